// File: rtl/core/dltq_pkg.sv
// Shared types and constants for the delta list timer queue.
`timescale 1ns / 1ps
package dltq_pkg;
    localparam int unsigned SlotCountDefault = 16;
    localparam int unsigned MaxResults = 16;
    localparam int unsigned HandleWidth = 4;
    localparam int unsigned DataWidth = 32;

    typedef enum logic [1:0] {
        CMD_SET    = 2'd0,
        CMD_CANCEL = 2'd1,
        CMD_TICK   = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_SET    = 2'd0,
        KIND_CANCEL = 2'd1,
        KIND_EXPIRY = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_ARGS  = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // capture input item
        logic walk_start;  // point cursor at head, clear prev
        logic walk_step;   // advance cursor, subtract delta from working delay
        logic cancel_step; // advance cursor without subtracting
        logic set_commit;  // link the new slot in
        logic cancel_commit;
        logic tick_dec;    // decrement head delta
        logic pop;         // unlink the head and present it
        logic rsp_load;    // present a set or cancel answer
        t_status rsp_status;
        logic out_last;
    } t_ctl;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_cmd cmd;
        logic bad_args;
        logic full;
        logic cancel_bad;
        logic cur_end;     // cursor is at the end of the list
        logic stop_set;    // working delay is below cursor delta
        logic cur_is_h;    // cursor equals the cancel handle
        logic head_empty;
        logic head_due;    // head delta at or below zero
    } t_sts;
endpackage

// File: rtl/core/dltq_ctrl.sv
// Controller state machine of the timer queue.
`timescale 1ns / 1ps
module dltq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  dltq_pkg::t_sts   i_sts,
    output dltq_pkg::t_ctl   o_ctl
);
    import dltq_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_DEC    = 8'b0000_0010,
        S_WALK   = 8'b0000_0100,
        S_CWALK  = 8'b0000_1000,
        S_POPCHK = 8'b0001_0000,
        S_OUT    = 8'b0010_0000,
        S_POPOUT = 8'b0100_0000,
        S_SETUP  = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic [4:0] r_cnt, n_cnt;
    logic r_valid, n_valid;

    assign o_in_ready = (r_state == S_IDLE);
    assign o_out_valid = r_valid;

    always_comb begin
        n_state = r_state;
        n_cnt = r_cnt;
        n_valid = r_valid;
        o_ctl = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctl.load = 1'b1;
                    n_state = S_SETUP;
                end
            end
            // Decide what the captured item needs.
            S_SETUP: begin
                case (i_sts.cmd)
                    CMD_SET: begin
                        if (i_sts.bad_args || i_sts.full) begin
                            o_ctl.rsp_load = 1'b1;
                            o_ctl.rsp_status = i_sts.bad_args ? ST_BAD_ARGS : ST_FULL;
                            o_ctl.out_last = 1'b1;
                            n_valid = 1'b1;
                            n_state = S_OUT;
                        end else begin
                            o_ctl.walk_start = 1'b1;
                            n_state = S_WALK;
                        end
                    end
                    CMD_CANCEL: begin
                        if (i_sts.cancel_bad) begin
                            o_ctl.rsp_load = 1'b1;
                            o_ctl.rsp_status = ST_NOT_FOUND;
                            o_ctl.out_last = 1'b1;
                            n_valid = 1'b1;
                            n_state = S_OUT;
                        end else begin
                            o_ctl.walk_start = 1'b1;
                            n_state = S_CWALK;
                        end
                    end
                    CMD_TICK: begin
                        n_state = i_sts.head_empty ? S_IDLE : S_DEC;
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            // Walk until the insert point.
            S_WALK: begin
                if (i_sts.cur_end || i_sts.stop_set) begin
                    o_ctl.set_commit = 1'b1;
                    o_ctl.rsp_load = 1'b1;
                    o_ctl.rsp_status = ST_OK;
                    o_ctl.out_last = 1'b1;
                    n_valid = 1'b1;
                    n_state = S_OUT;
                end else begin
                    o_ctl.walk_step = 1'b1;
                end
            end
            // Walk until the cancel handle.
            S_CWALK: begin
                if (i_sts.cur_is_h) begin
                    o_ctl.cancel_commit = 1'b1;
                    o_ctl.rsp_load = 1'b1;
                    o_ctl.rsp_status = ST_OK;
                    o_ctl.out_last = 1'b1;
                    n_valid = 1'b1;
                    n_state = S_OUT;
                end else if (i_sts.cur_end) begin
                    o_ctl.rsp_load = 1'b1;
                    o_ctl.rsp_status = ST_NOT_FOUND;
                    o_ctl.out_last = 1'b1;
                    n_valid = 1'b1;
                    n_state = S_OUT;
                end else begin
                    o_ctl.cancel_step = 1'b1;
                end
            end
            S_DEC: begin
                o_ctl.tick_dec = 1'b1;
                n_cnt = '0;
                n_state = S_POPCHK;
            end
            // Pop one due head entry per pass; the capped pop is always last.
            S_POPCHK: begin
                if (!i_sts.head_empty && i_sts.head_due && r_cnt < 5'(MaxResults)) begin
                    o_ctl.pop = 1'b1;
                    o_ctl.out_last = (r_cnt == 5'(MaxResults - 1));
                    n_cnt = r_cnt + 5'd1;
                    n_valid = 1'b1;
                    n_state = S_POPOUT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_POPOUT: begin
                if (i_out_ready) begin
                    n_valid = 1'b0;
                    n_state = S_POPCHK;
                end
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_valid = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt <= n_cnt;
            r_valid <= n_valid;
        end
    end
endmodule

// File: rtl/core/dltq_dpath.sv
// Datapath of the timer queue: slot store, list links and result register.
`timescale 1ns / 1ps
module dltq_dpath #(
    parameter int unsigned SLOT_COUNT = dltq_pkg::SlotCountDefault
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [1:0]       i_command,
    input  logic [31:0]      i_delay,
    input  logic [31:0]      i_callback_id,
    input  logic [31:0]      i_callback_arg,
    input  logic [3:0]       i_cancel_handle,
    input  dltq_pkg::t_ctl   i_ctl,
    output dltq_pkg::t_sts   o_sts,
    output logic [1:0]       o_kind,
    output logic [1:0]       o_status,
    output logic [3:0]       o_handle,
    output logic [31:0]      o_expired_callback,
    output logic [31:0]      o_expired_arg,
    output logic             o_last
);
    import dltq_pkg::*;

    localparam int unsigned PW = $clog2(SLOT_COUNT + 1);
    localparam int unsigned IW = $clog2(SLOT_COUNT);
    localparam logic [PW-1:0] NIL = PW'(SLOT_COUNT);

    logic [31:0]   r_delta [SLOT_COUNT];
    logic [31:0]   r_cb    [SLOT_COUNT];
    logic [31:0]   r_arg   [SLOT_COUNT];
    logic [PW-1:0] r_succ  [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] r_used;
    logic [PW-1:0] r_head, r_cur, r_prev;
    logic [1:0]  r_cmd;
    logic [31:0] r_d, r_icb, r_iarg;
    logic [3:0]  r_h;

    logic [IW-1:0] free_idx;
    logic          free_ok;
    logic [IW-1:0] cur_i, prev_i, head_i, h_i;
    logic [31:0]   cur_delta, head_delta;
    logic          h_in_range;

    assign cur_i = r_cur[IW-1:0];
    assign prev_i = r_prev[IW-1:0];
    assign head_i = r_head[IW-1:0];
    assign h_in_range = ({{PW{1'b0}}, r_h} < {4'd0, NIL});
    assign h_i = IW'(r_h);
    assign cur_delta = r_delta[cur_i];
    assign head_delta = r_delta[head_i];

    // Find the lowest free slot.
    always_comb begin
        free_idx = '0;
        free_ok = 1'b0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                free_idx = IW'(i);
                free_ok = 1'b1;
            end
        end
    end

    always_comb begin
        o_sts.cmd = t_cmd'(r_cmd);
        o_sts.bad_args = ($signed(r_d) <= 0) || (r_icb == '0);
        o_sts.full = !free_ok;
        o_sts.cancel_bad = !h_in_range || !r_used[h_i];
        o_sts.cur_end = (r_cur == NIL);
        o_sts.stop_set = $signed(r_d) < $signed(cur_delta);
        o_sts.cur_is_h = (r_cur == PW'(r_h)) && h_in_range;
        o_sts.head_empty = (r_head == NIL);
        o_sts.head_due = $signed(head_delta) <= 0;
    end

    // Control registers: list head and slot usage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
            r_head <= NIL;
        end else begin
            if (i_ctl.set_commit) begin
                r_used[free_idx] <= 1'b1;
                if (r_prev == NIL) r_head <= PW'(free_idx);
            end
            if (i_ctl.cancel_commit) begin
                r_used[h_i] <= 1'b0;
                if (r_prev == NIL) r_head <= r_succ[h_i];
            end
            if (i_ctl.pop) begin
                r_used[head_i] <= 1'b0;
                r_head <= r_succ[head_i];
            end
        end
    end

    // Slot store and working registers.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd <= i_command;
            r_d <= i_delay;
            r_icb <= i_callback_id;
            r_iarg <= i_callback_arg;
            r_h <= i_cancel_handle;
        end
        if (i_ctl.walk_start) begin
            r_cur <= r_head;
            r_prev <= NIL;
        end
        if (i_ctl.walk_step) begin
            r_d <= r_d - cur_delta;
            r_prev <= r_cur;
            r_cur <= r_succ[cur_i];
        end
        if (i_ctl.cancel_step) begin
            r_prev <= r_cur;
            r_cur <= r_succ[cur_i];
        end
        if (i_ctl.set_commit) begin
            if (r_cur != NIL) r_delta[cur_i] <= cur_delta - r_d;
            r_delta[free_idx] <= r_d;
            r_cb[free_idx] <= r_icb;
            r_arg[free_idx] <= r_iarg;
            r_succ[free_idx] <= r_cur;
            if (r_prev != NIL) r_succ[prev_i] <= PW'(free_idx);
        end
        if (i_ctl.cancel_commit) begin
            if (r_succ[h_i] != NIL)
                r_delta[r_succ[h_i][IW-1:0]] <= r_delta[r_succ[h_i][IW-1:0]] + r_delta[h_i];
            if (r_prev != NIL) r_succ[prev_i] <= r_succ[h_i];
        end
        if (i_ctl.tick_dec) r_delta[head_i] <= head_delta - 32'd1;
        if (i_ctl.pop) begin
            if (r_succ[head_i] != NIL)
                r_delta[r_succ[head_i][IW-1:0]] <= r_delta[r_succ[head_i][IW-1:0]] + head_delta;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_ctl.rsp_load) begin
            o_kind <= (r_cmd == CMD_SET) ? KIND_SET : KIND_CANCEL;
            o_status <= i_ctl.rsp_status;
            o_handle <= (r_cmd == CMD_SET) ?
                ((i_ctl.rsp_status == ST_OK) ? 4'(free_idx) : 4'd0) : r_h;
            o_expired_callback <= '0;
            o_expired_arg <= '0;
            o_last <= i_ctl.out_last;
        end
        if (i_ctl.pop) begin
            o_kind <= KIND_EXPIRY;
            o_status <= ST_OK;
            o_handle <= 4'(head_i);
            o_expired_callback <= r_cb[head_i];
            o_expired_arg <= r_arg[head_i];
            // Last at the pop cap or if nothing further can pop this tick.
            o_last <= i_ctl.out_last || (r_succ[head_i] == NIL) ||
                      ($signed(r_delta[r_succ[head_i][IW-1:0]] + head_delta) > 0);
        end
    end
endmodule

// File: rtl/core/delta_list_timer_queue_core.sv
// Top level of the delta list timer queue.
`timescale 1ns / 1ps
// Timer queue kept as a delta list over SLOT_COUNT slots.
// Input channel s_axis: one command item (set, cancel or tick).
// Output channel m_axis: answers and expiry events; tlast marks the final
// result of an input item. A set or cancel gives one answer; a tick gives
// zero or more expiry events (up to 16).
// A set walks the list one link per cycle over up to SLOT_COUNT entries;
// a cancel likewise. A tick decrements the head delta and then pops each
// due expiry in turn, waiting for the receiver after each one.
// One item is worked at a time; s_axis_tready is high only when idle.
// Reset empties the list and frees all slots at once.
// When the receiver stalls, the result register holds and the block waits.
// The last expiry of a tick is tlast; the sixteenth pop of a tick always
// carries tlast, and entries still due then pop on later ticks.
module delta_list_timer_queue_core #(
    parameter int unsigned SLOT_COUNT = dltq_pkg::SlotCountDefault
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // command[1:0], delay[33:2], callback_id[65:34], callback_arg[97:66],
    // cancel_handle[101:98], zero fill to 104
    input  logic [103:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // kind[1:0], status[3:2], handle[7:4], expired_callback[39:8],
    // expired_arg[71:40]
    output logic [71:0]  m_axis_tdata,
    output logic         m_axis_tlast
);
    import dltq_pkg::*;

    t_ctl ctl;
    t_sts sts;
    logic [1:0] kind, status;
    logic [3:0] handle;
    logic [31:0] ecb, earg;

    dltq_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_sts(sts), .o_ctl(ctl)
    );

    dltq_dpath #(.SLOT_COUNT(SLOT_COUNT)) u_dpath (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_command(s_axis_tdata[1:0]),
        .i_delay(s_axis_tdata[33:2]),
        .i_callback_id(s_axis_tdata[65:34]),
        .i_callback_arg(s_axis_tdata[97:66]),
        .i_cancel_handle(s_axis_tdata[101:98]),
        .i_ctl(ctl), .o_sts(sts),
        .o_kind(kind), .o_status(status), .o_handle(handle),
        .o_expired_callback(ecb), .o_expired_arg(earg),
        .o_last(m_axis_tlast)
    );

    assign m_axis_tdata = {earg, ecb, handle, status, kind};
endmodule

// File: rtl/core/dltq_checker.sv
// Port-level checker for the timer queue, bound to the top level.
`timescale 1ns / 1ps
module dltq_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [71:0]  m_axis_tdata,
    input logic         m_axis_tlast
);
    import dltq_pkg::*;

    // No input taken while a result is pending.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("input ready with result pending");

    // Stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed under stall");

    // Answers are always last.
    a_ans_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[1:0] == KIND_SET || m_axis_tdata[1:0] == KIND_CANCEL)
        |-> m_axis_tlast) else $error("answer not last");

    // Expiries carry status ok.
    a_exp_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[1:0] == KIND_EXPIRY |-> m_axis_tdata[3:2] == ST_OK)
        else $error("expiry with bad status");
endmodule

bind delta_list_timer_queue_core dltq_checker u_dltq_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
);

// File: dv/delta_list_timer_queue_core_test.sv
// Self-checking testbench for the delta list timer queue core.
`timescale 1ns / 1ps
module delta_list_timer_queue_core_test;
    import dltq_pkg::*;

    localparam int Slots = 16;
    localparam int RandomItems = 250;

    typedef struct {
        t_cmd        cmd;
        logic [31:0] delay;
        logic [31:0] callback;
        logic [31:0] argument;
        logic [3:0]  handle;
    } timer_cmd_t;

    typedef struct {
        t_kind       kind;
        t_status     status;
        logic [3:0]  handle;
        logic [31:0] callback;
        logic [31:0] argument;
        logic        last;
    } timer_rsp_t;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // command[1:0], delay[33:2], callback_id[65:34], callback_arg[97:66],
    // cancel_handle[101:98], zero fill to 104
    logic [103:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // kind[1:0], status[3:2], handle[7:4], expired_callback[39:8],
    // expired_arg[71:40]
    logic [71:0]  m_axis_tdata;
    logic         m_axis_tlast;

    delta_list_timer_queue_core #(.SLOT_COUNT(Slots)) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast)
    );

    // Shadow copy of the timer store
    logic [31:0] shadow_delta[Slots];
    logic [31:0] shadow_callback[Slots];
    logic [31:0] shadow_argument[Slots];
    int          shadow_next[Slots];
    bit          shadow_busy[Slots];
    int          shadow_head = Slots;

    timer_cmd_t command_queue[$];
    timer_rsp_t expected_rsps[$];
    timer_cmd_t driven_cmd;
    int         total_cmds;
    int         accepted_cmds = 0;
    int         send_gap = 0;
    int         recv_stall = 0;
    int         quiet_left = 0;
    bit         failed = 0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int r;
        if (quiet_left > 0) begin
            quiet_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) quiet_left = $urandom_range(10, 40);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic void expect_rsp(t_kind k, t_status s, int h, logic [31:0] cb,
                                       logic [31:0] arg, bit last);
        timer_rsp_t r;
        r.kind = k;
        r.status = s;
        r.handle = h[3:0];
        r.callback = cb;
        r.argument = arg;
        r.last = last;
        expected_rsps.push_back(r);
    endfunction

    // Work out the answers a command produces and update the shadow store
    function automatic void predict_timer(timer_cmd_t c);
        int slot, prev, cur, nxt, n;
        logic [31:0] d;
        slot = Slots;
        prev = Slots;
        n = 0;
        d = c.delay;
        case (c.cmd)
            CMD_SET: begin
                if ($signed(d) <= 0 || c.callback == 0) begin
                    expect_rsp(KIND_SET, ST_BAD_ARGS, 0, 32'd0, 32'd0, 1'b1);
                    return;
                end
                for (int i = Slots - 1; i >= 0; i--)
                    if (!shadow_busy[i]) slot = i;
                if (slot == Slots) begin
                    expect_rsp(KIND_SET, ST_FULL, 0, 32'd0, 32'd0, 1'b1);
                    return;
                end
                // walk to the first entry expiring strictly later
                cur = shadow_head;
                for (int i = 0; i < Slots && cur < Slots; i++) begin
                    if ($signed(d) < $signed(shadow_delta[cur])) break;
                    d -= shadow_delta[cur];
                    prev = cur;
                    cur = shadow_next[cur];
                end
                if (cur < Slots) shadow_delta[cur] -= d;
                shadow_delta[slot] = d;
                shadow_callback[slot] = c.callback;
                shadow_argument[slot] = c.argument;
                shadow_next[slot] = cur;
                shadow_busy[slot] = 1;
                if (prev == Slots) shadow_head = slot;
                else shadow_next[prev] = slot;
                expect_rsp(KIND_SET, ST_OK, slot, 32'd0, 32'd0, 1'b1);
            end
            CMD_CANCEL: begin
                if (!shadow_busy[c.handle]) begin
                    expect_rsp(KIND_CANCEL, ST_NOT_FOUND, c.handle, 32'd0, 32'd0, 1'b1);
                    return;
                end
                cur = shadow_head;
                for (int i = 0; i < Slots && cur < Slots && cur != c.handle; i++) begin
                    prev = cur;
                    cur = shadow_next[cur];
                end
                if (cur != c.handle) begin
                    expect_rsp(KIND_CANCEL, ST_NOT_FOUND, c.handle, 32'd0, 32'd0, 1'b1);
                    return;
                end
                nxt = shadow_next[cur];
                if (nxt < Slots) shadow_delta[nxt] += shadow_delta[cur];
                if (prev == Slots) shadow_head = nxt;
                else shadow_next[prev] = nxt;
                shadow_busy[cur] = 0;
                expect_rsp(KIND_CANCEL, ST_OK, c.handle, 32'd0, 32'd0, 1'b1);
            end
            CMD_TICK: begin
                if (shadow_head >= Slots) return;
                shadow_delta[shadow_head] -= 1;
                // pop every due head entry, up to the cap
                while (n < MaxResults && shadow_head < Slots &&
                       $signed(shadow_delta[shadow_head]) <= 0) begin
                    cur = shadow_head;
                    nxt = shadow_next[cur];
                    if (nxt < Slots) shadow_delta[nxt] += shadow_delta[cur];
                    shadow_head = nxt;
                    shadow_busy[cur] = 0;
                    expect_rsp(KIND_EXPIRY, ST_OK, cur, shadow_callback[cur],
                               shadow_argument[cur], 1'b0);
                    n++;
                end
                if (n > 0) expected_rsps[$].last = 1'b1;
            end
            default: ;
        endcase
    endfunction

    task automatic add_cmd(t_cmd cmd, logic [31:0] delay, logic [31:0] cb,
                           logic [31:0] arg, logic [3:0] h);
        timer_cmd_t c;
        c.cmd = cmd;
        c.delay = delay;
        c.callback = cb;
        c.argument = arg;
        c.handle = h;
        command_queue.push_back(c);
    endtask

    // Drive command items
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_timer(driven_cmd);
                accepted_cmds++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (command_queue.size() > 0) begin
                    driven_cmd = command_queue.pop_front();
                    s_axis_tdata <= {2'b00, driven_cmd.handle, driven_cmd.argument,
                                     driven_cmd.callback, driven_cmd.delay, driven_cmd.cmd};
                    s_axis_tvalid <= 1'b1;
                    send_gap = pick_gap();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Accept and check results
    always @(posedge i_clk) begin
        timer_rsp_t e;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_rsps.size() == 0) begin
                    $error("unexpected result: tdata=%h tlast=%b", m_axis_tdata, m_axis_tlast);
                    failed = 1;
                end else begin
                    e = expected_rsps.pop_front();
                    if (m_axis_tdata[1:0] !== e.kind) begin
                        $error("kind: expected %0d, got %0d", e.kind, m_axis_tdata[1:0]);
                        failed = 1;
                    end
                    if (m_axis_tdata[3:2] !== e.status) begin
                        $error("status: expected %0d, got %0d", e.status, m_axis_tdata[3:2]);
                        failed = 1;
                    end
                    if (m_axis_tdata[7:4] !== e.handle) begin
                        $error("handle: expected %0d, got %0d", e.handle, m_axis_tdata[7:4]);
                        failed = 1;
                    end
                    if (m_axis_tdata[39:8] !== e.callback) begin
                        $error("expired_callback: expected %h, got %h", e.callback,
                               m_axis_tdata[39:8]);
                        failed = 1;
                    end
                    if (m_axis_tdata[71:40] !== e.argument) begin
                        $error("expired_arg: expected %h, got %h", e.argument,
                               m_axis_tdata[71:40]);
                        failed = 1;
                    end
                    if (m_axis_tlast !== e.last) begin
                        $error("last: expected %0d, got %0d", e.last, m_axis_tlast);
                        failed = 1;
                    end
                end
            end
            // stall the receiver now and then
            if (recv_stall > 0) begin
                recv_stall--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                recv_stall = pick_gap();
            end
        end
    end

    // Fill the command queue, then wait for the last result
    initial begin
        int r;
        logic [31:0] dly;
        // directed: empty list, refused arguments, extremes
        add_cmd(CMD_TICK, 0, 0, 0, 4'd0);
        add_cmd(CMD_CANCEL, 0, 0, 0, 4'd0);
        add_cmd(CMD_CANCEL, 0, 0, 0, 4'd15);
        add_cmd(CMD_SET, 32'd0, 32'd5, 32'd1, 4'd0);
        add_cmd(CMD_SET, 32'hffff_ffff, 32'd5, 32'd1, 4'd0);
        add_cmd(CMD_SET, 32'h8000_0000, 32'd5, 32'd1, 4'd0);
        add_cmd(CMD_SET, 32'd3, 32'd0, 32'd1, 4'd0);
        add_cmd(CMD_SET, 32'h7fff_ffff, 32'hffff_ffff, 32'hffff_ffff, 4'd0);
        add_cmd(CMD_NONE, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 4'hf);
        add_cmd(CMD_CANCEL, 0, 0, 0, 4'd0);
        // fill the store with equal expiry times, then overflow it
        for (int i = 0; i < Slots; i++)
            add_cmd(CMD_SET, 32'd2, 32'h100 + i, 32'h200 + i, 4'd0);
        add_cmd(CMD_SET, 32'd1, 32'd7, 32'd7, 4'd0);
        add_cmd(CMD_TICK, 0, 0, 0, 4'd0);
        // all sixteen fall due on one tick
        add_cmd(CMD_TICK, 0, 0, 0, 4'd0);
        add_cmd(CMD_TICK, 0, 0, 0, 4'd0);
        // random: mostly well-formed sets, cancels and ticks
        for (int i = 0; i < RandomItems; i++) begin
            r = $urandom_range(0, 99);
            if (r < 40) begin
                dly = $urandom_range(1, 8);
                if ($urandom_range(0, 9) == 0) dly = $urandom();
                add_cmd(CMD_SET, dly, ($urandom_range(0, 19) == 0) ? 32'd0 : $urandom(),
                        $urandom(), 4'($urandom()));
            end else if (r < 62) begin
                add_cmd(CMD_CANCEL, $urandom(), $urandom(), $urandom(),
                        4'($urandom_range(0, 15)));
            end else if (r < 97) begin
                add_cmd(CMD_TICK, $urandom(), $urandom(), $urandom(), 4'($urandom()));
            end else begin
                add_cmd(CMD_NONE, $urandom(), $urandom(), $urandom(), 4'($urandom()));
            end
        end
        // drain the list
        for (int i = 0; i < 12; i++)
            add_cmd(CMD_TICK, 0, 0, 0, 4'd0);
        total_cmds = command_queue.size();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(negedge i_clk);
        while (accepted_cmds != total_cmds || expected_rsps.size() != 0);
        repeat (80) @(negedge i_clk);
        if (!failed && expected_rsps.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end
endmodule
